/* sv/bvs_pkg.sv */
package bvs_pkg;

	// Port field widths
	localparam int CMD_W  = 3;
	localparam int POS_W  = 11;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 11;

	// Parameter defaults
	localparam int DEPTH_DEF = 1024;
	localparam int WIDTH_DEF = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_FRONT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_BACK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		DP_NONE,
		DP_LATCH,
		DP_EXEC_SIMPLE,
		DP_RD_ISSUE,
		DP_RD_DONE,
		DP_SH_RD,
		DP_SH_WR,
		DP_INS_WR
	} dp_op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic simple;       // finishes in one step: errors, push, pop, clear, unused code
		logic is_read;      // successful read_at, read_front or read_back
		logic needs_shift;  // insert below the current end
		logic ptr_at_pos;   // shift pointer reached the insert position
		logic out_free;     // result register can take a new result
	} dp_stat_t;

endpackage

/* sv/bvs_datapath.sv */
module bvs_datapath #(
	parameter int DEPTH = bvs_pkg::DEPTH_DEF,
	parameter int WIDTH = bvs_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bvs_pkg::dp_op_t              op,
	output bvs_pkg::dp_stat_t            stat,
	input  logic [bvs_pkg::CMD_W-1:0]    cmd,
	input  logic [bvs_pkg::POS_W-1:0]    position,
	input  logic [bvs_pkg::DATA_W-1:0]   write_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bvs_pkg::STAT_W-1:0]   status,
	output logic [bvs_pkg::DATA_W-1:0]   read_value,
	output logic [bvs_pkg::CNT_W-1:0]    count,
	output logic [bvs_pkg::CNT_W-1:0]    cap_now
);
	import bvs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_X = (CW+1)'(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];

	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [WIDTH-1:0]  val_q;
	logic [AW-1:0]     ptr_q;
	logic [WIDTH-1:0]  rdata_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     cap_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [WIDTH-1:0]  read_q;
	logic [CW-1:0]     out_count_q;
	logic [CW-1:0]     out_cap_q;

	logic [63:0]       wv_ext;
	logic [63:0]       read_ext;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     ptr_x;
	logic              full;
	logic              empty;
	logic [STAT_W-1:0] chk;
	logic [CW:0]       cap_dbl;
	logic [CW-1:0]     cap_grow;
	logic [CW-1:0]     cap_shrink;
	logic [CW-1:0]     count_nxt;
	logic [CW-1:0]     cap_nxt;
	logic              load;
	logic [STAT_W-1:0] load_status;
	logic              load_read;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [WIDTH-1:0]  mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	assign wv_ext = {32'd0, write_value};
	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign ptr_x  = XW'(ptr_q);
	assign full   = (count_q == DEPTH_C);
	assign empty  = (count_q == '0);

	always_comb begin
		case (cmd_q)
			CMD_PUSH_BACK: chk = full ? ST_FULL : ST_OK;
			CMD_INSERT: begin
				if (pos_x > cnt_x)
					chk = ST_INDEX;
				else
					chk = full ? ST_FULL : ST_OK;
			end
			CMD_POP_BACK, CMD_READ_FRONT, CMD_READ_BACK: chk = empty ? ST_EMPTY : ST_OK;
			CMD_READ_AT: begin
				if (empty)
					chk = ST_EMPTY;
				else
					chk = (pos_x >= cnt_x) ? ST_INDEX : ST_OK;
			end
			default: chk = ST_OK;
		endcase
	end

	// Grow on an add into a full logical capacity, saturating at DEPTH
	assign cap_dbl  = {cap_q, 1'b0};
	assign cap_grow = (count_q < cap_q) ? cap_q :
		((cap_dbl > DEPTH_X) ? DEPTH_C : cap_dbl[CW-1:0]);
	// Halve when the count left after a pop equals a quarter of capacity
	assign cap_shrink = (cap_q > CW'(1) && (count_q - CW'(1)) == (cap_q >> 2)) ?
		(cap_q >> 1) : cap_q;

	always_comb begin
		stat.simple      = (chk != ST_OK) || !(cmd_q == CMD_INSERT ||
			cmd_q == CMD_READ_AT || cmd_q == CMD_READ_FRONT || cmd_q == CMD_READ_BACK);
		stat.is_read     = (chk == ST_OK) && (cmd_q == CMD_READ_AT ||
			cmd_q == CMD_READ_FRONT || cmd_q == CMD_READ_BACK);
		stat.needs_shift = (pos_x != cnt_x);
		stat.ptr_at_pos  = (ptr_x == pos_x);
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_comb begin
		count_nxt   = count_q;
		cap_nxt     = cap_q;
		load        = 1'b0;
		load_status = ST_OK;
		load_read   = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = AW'(count_q);
		mem_wd      = val_q;
		mem_re      = 1'b0;
		mem_ra      = ptr_q;
		case (op)
			DP_EXEC_SIMPLE: begin
				load        = 1'b1;
				load_status = chk;
				if (chk == ST_OK) begin
					case (cmd_q)
						CMD_PUSH_BACK: begin
							mem_we    = 1'b1;
							count_nxt = count_q + CW'(1);
							cap_nxt   = cap_grow;
						end
						CMD_POP_BACK: begin
							count_nxt = count_q - CW'(1);
							cap_nxt   = cap_shrink;
						end
						CMD_CLEAR: count_nxt = '0;
						default: ;
					endcase
				end
			end
			DP_RD_ISSUE: begin
				mem_re = 1'b1;
				case (cmd_q)
					CMD_READ_AT:    mem_ra = AW'(pos_q);
					CMD_READ_FRONT: mem_ra = '0;
					default:        mem_ra = AW'(count_q - CW'(1));
				endcase
			end
			DP_RD_DONE: begin
				load      = 1'b1;
				load_read = 1'b1;
			end
			DP_SH_RD: mem_re = 1'b1;
			DP_SH_WR: begin
				mem_we = 1'b1;
				mem_wa = ptr_q + AW'(1);
				mem_wd = rdata_q;
			end
			DP_INS_WR: begin
				mem_we    = 1'b1;
				mem_wa    = AW'(pos_q);
				count_nxt = count_q + CW'(1);
				cap_nxt   = cap_grow;
				load      = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (op == DP_LATCH) begin
			cmd_q <= cmd;
			pos_q <= position;
			val_q <= wv_ext[WIDTH-1:0];
			ptr_q <= AW'(count_q - CW'(1));
		end else if (op == DP_SH_WR) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (load) begin
			status_q    <= load_status;
			read_q      <= load_read ? rdata_q : '0;
			out_count_q <= count_nxt;
			out_cap_q   <= cap_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			cap_q   <= cap_nxt;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign read_ext   = 64'(read_q);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_ext[DATA_W-1:0];
	assign count      = CNT_W'(out_count_q);
	assign cap_now    = CNT_W'(out_cap_q);

endmodule

/* sv/bvs_ctrl.sv */
module bvs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bvs_pkg::dp_stat_t  stat,
	output bvs_pkg::dp_op_t    op
);
	import bvs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		op        = DP_NONE;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op        = DP_LATCH;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register has room
				if (stat.out_free) begin
					if (stat.simple) begin
						op        = DP_EXEC_SIMPLE;
						state_nxt = S_IDLE;
					end else if (stat.is_read) begin
						op        = DP_RD_ISSUE;
						state_nxt = S_RD;
					end else if (stat.needs_shift) begin
						state_nxt = S_SH_RD;
					end else begin
						state_nxt = S_INS_WR;
					end
				end
			end
			S_RD: begin
				op        = DP_RD_DONE;
				state_nxt = S_IDLE;
			end
			S_SH_RD: begin
				op        = DP_SH_RD;
				state_nxt = S_SH_WR;
			end
			S_SH_WR: begin
				// move one element up, stop after the one at the insert position
				op        = DP_SH_WR;
				state_nxt = stat.ptr_at_pos ? S_INS_WR : S_SH_RD;
			end
			S_INS_WR: begin
				op        = DP_INS_WR;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

/* sv/bounded_vector_store.sv */
// Ordered element store of up to DEPTH entries of WIDTH bits.
// Input channel (in_valid/in_ready) carries one request: cmd, position and
// write_value. Output channel (out_valid/out_ready) returns one result per
// request: status, read_value, count and cap_now, all taken after the request.
// One request is worked on at a time; in_ready is high while the controller
// is idle, even if the previous result still waits in the output register.
// Steps from acceptance to result valid:
//   push_back, pop_back, clear, unused code and any error: one execute step
//   read_at, read_front, read_back: one registered memory read, then the load
//   insert: each element from position up to the end is moved up by one,
//   each with a read and a write on the single element memory, then the new
//   value is written at position. With the output drained the next request
// is accepted once the controller is back in idle, as the result turns valid.
// When out_ready is low the result stays in the output register; a following
// request is accepted but its result waits until the register drains.
// Reset clears the count to zero and the capacity to one; element memory is
// not cleared, so the block takes requests right after reset.
module bounded_vector_store #(
	parameter int DEPTH = bvs_pkg::DEPTH_DEF,
	parameter int WIDTH = bvs_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bvs_pkg::CMD_W-1:0]    cmd,
	input  logic [bvs_pkg::POS_W-1:0]    position,
	input  logic [bvs_pkg::DATA_W-1:0]   write_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bvs_pkg::STAT_W-1:0]   status,
	output logic [bvs_pkg::DATA_W-1:0]   read_value,
	output logic [bvs_pkg::CNT_W-1:0]    count,
	output logic [bvs_pkg::CNT_W-1:0]    cap_now
);
	import bvs_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	bvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op)
	);

	bvs_datapath #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.cmd         (cmd),
		.position    (position),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_value  (read_value),
		.count       (count),
		.cap_now     (cap_now)
	);

endmodule
